>>> design/tvms_pkg.sv
// ----------------------------------------------------------------------------
// tvms_pkg
// types and constants shared by the melody sequencer modules
// ----------------------------------------------------------------------------
package tvms_pkg;

    localparam logic [2:0] REQ_TICK   = 3'd0;
    localparam logic [2:0] REQ_NOTE   = 3'd1;
    localparam logic [2:0] REQ_DEFINE = 3'd2;
    localparam logic [2:0] REQ_LOOP   = 3'd3;
    localparam logic [2:0] REQ_EFFECT = 3'd4;
    localparam logic [2:0] REQ_STOP   = 3'd5;

    localparam int QW = 18;
    localparam logic [QW-1:0] Q_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERD,      // effect: read song slot
        ST_ENOTE,    // effect: slot data back, read note
        ST_EDIV,
        ST_EPER,     // effect: period divide
        ST_LRD,
        ST_LNOTE,
        ST_LDIV,
        ST_LPER,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic [19:0] dividend;
        logic [11:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [19:0] quot;
    } div_rsp_t;

endpackage

>>> design/tvms_div.sv
// ----------------------------------------------------------------------------
// tvms_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tvms_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  tvms_pkg::div_req_t req,
    output tvms_pkg::div_rsp_t rsp
);

    logic [19:0] quot_reg, quot_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[19]};
        if (req.start)
        begin
            quot_next = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'd19;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = 12'(trial - {1'b0, dvs_reg});
                quot_next = {quot_reg[18:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[11:0];
                quot_next = {quot_reg[18:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> design/two_voice_melody_sequencer.sv
// ----------------------------------------------------------------------------
// two_voice_melody_sequencer
// buzzer sequencer with a looping song and a one-shot effect
// ----------------------------------------------------------------------------
// One request is handled at a time. Note writes, song definitions and play or
// stop commands go through the ST_OUT state, which sets the result register. In
// a tick each active voice reads its song slot and then its note from the note
// memory, then the shared bit-serial divider works out the note length and,
// when a tone starts, the period. A tone starts on one voice at most per tick.
// Divider time sets the rate. The result of a request is held in an output
// register until taken; the next request is taken once it is.
module two_voice_melody_sequencer #(
    parameter int NOTE_DEPTH = 256,
    parameter int SONG_SLOTS = 4,
    parameter int GAP_MS     = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  req_type,
    input  logic [1:0]  song,
    input  logic [7:0]  note_addr,
    input  logic [11:0] note_freq,
    input  logic [4:0]  note_sixteenths,
    input  logic [7:0]  first_addr,
    input  logic [8:0]  note_count,
    input  logic [8:0]  bpm,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        tone_enable,
    output logic [15:0] tone_period_us,
    output logic [14:0] tone_compare,
    output logic        loop_active,
    output logic        effect_active
);

    localparam int AW = (NOTE_DEPTH > 1) ? $clog2(NOTE_DEPTH) : 1;
    localparam int SW = (SONG_SLOTS > 1) ? $clog2(SONG_SLOTS) : 1;
    localparam logic [tvms_pkg::QW-1:0] GAP = tvms_pkg::QW'(GAP_MS);

    // memories
    logic [16:0] note_mem [NOTE_DEPTH];
    logic [25:0] slot_mem [SONG_SLOTS];
    logic [16:0] note_rd;
    logic [25:0] slot_rd;

    tvms_pkg::state_t state_reg, state_next;

    logic [2:0]  req_reg;
    logic [1:0]  song_reg;
    logic        loop_on_reg, loop_on_next;
    logic [SW-1:0] loop_slot_reg, loop_slot_next;
    logic [7:0]  loop_pos_reg, loop_pos_next;
    logic [17:0] loop_ms_reg, loop_ms_next;
    logic        eff_on_reg, eff_on_next;
    logic [SW-1:0] eff_slot_reg, eff_slot_next;
    logic [7:0]  eff_pos_reg, eff_pos_next;
    logic [17:0] eff_ms_reg, eff_ms_next;
    logic        run_reg, run_next;
    logic [15:0] period_reg, period_next;
    logic        ov_reg, ov_next;
    logic        div_go_reg, div_go_next;
    logic [16:0] note_reg, note_nxt;
    logic [25:0] slot_reg, slot_nxt;

    logic        rd_slot_en;
    logic [SW-1:0] rd_slot_addr;
    logic        rd_note_en;
    logic [AW-1:0] rd_note_addr;

    tvms_pkg::div_req_t dreq;
    tvms_pkg::div_rsp_t drsp;

    logic        take;
    logic        is_eff;
    logic [SW-1:0] cur_slot;
    logic [7:0]  cur_pos;
    logic [17:0] cur_ms;
    logic        audible;
    logic [11:0] freq;
    logic [17:0] q;
    logic [8:0]  cnt_eff;
    logic        ended;
    logic [7:0]  pos_n;
    logic [17:0] ms_n;
    logic        do_tone;
    logic        slot_ok;

    tvms_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign take    = in_valid && in_ready;
    assign in_ready = (state_reg == tvms_pkg::ST_IDLE) && !ov_reg;
    assign slot_ok = 32'(song_reg) < SONG_SLOTS;

    always_ff @(posedge clk)
    begin
        if (take && req_type == tvms_pkg::REQ_NOTE)
            note_mem[AW'(note_addr)] <= {note_freq, note_sixteenths};
        if (take && req_type == tvms_pkg::REQ_DEFINE && 32'(song) < SONG_SLOTS)
            slot_mem[SW'(song)] <= {first_addr, note_count, bpm};
        if (rd_slot_en)
            slot_rd <= slot_mem[rd_slot_addr];
        if (rd_note_en)
            note_rd <= note_mem[rd_note_addr];
        if (take)
        begin
            req_reg  <= req_type;
            song_reg <= song;
        end
        note_reg <= note_nxt;
        slot_reg <= slot_nxt;
    end

    // voice under work
    always_comb
    begin
        is_eff   = (state_reg == tvms_pkg::ST_ERD) || (state_reg == tvms_pkg::ST_ENOTE)
                || (state_reg == tvms_pkg::ST_EDIV) || (state_reg == tvms_pkg::ST_EPER);
        cur_slot = is_eff ? eff_slot_reg : loop_slot_reg;
        cur_pos  = is_eff ? eff_pos_reg  : loop_pos_reg;
        cur_ms   = is_eff ? eff_ms_reg   : loop_ms_reg;
        audible  = is_eff ? 1'b1 : !eff_on_reg;
        freq     = note_reg[16:5];
        if (slot_reg[8:0] == '0)
            q = tvms_pkg::Q_MAX;
        else if (drsp.quot > 20'(tvms_pkg::Q_MAX))
            q = tvms_pkg::Q_MAX;
        else
            q = drsp.quot[17:0];
        if (slot_reg[17:9] == '0)
            cnt_eff = 9'd1;
        else if (slot_reg[17:9] > 9'd256)
            cnt_eff = 9'd256;
        else
            cnt_eff = slot_reg[17:9];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tvms_pkg::ST_IDLE:
                if (take)
                    state_next = (req_type == tvms_pkg::REQ_TICK)
                               ? tvms_pkg::ST_ERD : tvms_pkg::ST_OUT;
            tvms_pkg::ST_ERD:
                state_next = eff_on_reg ? tvms_pkg::ST_ENOTE : tvms_pkg::ST_LRD;
            tvms_pkg::ST_ENOTE:  state_next = tvms_pkg::ST_EDIV;
            tvms_pkg::ST_EDIV:
                if (drsp.done)
                    state_next = do_tone ? tvms_pkg::ST_EPER : tvms_pkg::ST_LRD;
            tvms_pkg::ST_EPER:
                if (drsp.done)
                    state_next = tvms_pkg::ST_LRD;
            tvms_pkg::ST_LRD:
                state_next = loop_on_reg ? tvms_pkg::ST_LNOTE : tvms_pkg::ST_OUT;
            tvms_pkg::ST_LNOTE:  state_next = tvms_pkg::ST_LDIV;
            tvms_pkg::ST_LDIV:
                if (drsp.done)
                    state_next = do_tone ? tvms_pkg::ST_LPER : tvms_pkg::ST_OUT;
            tvms_pkg::ST_LPER:
                if (drsp.done)
                    state_next = tvms_pkg::ST_OUT;
            tvms_pkg::ST_OUT:    state_next = tvms_pkg::ST_IDLE;
            default:             state_next = tvms_pkg::ST_IDLE;
        endcase
    end

    // tick step of one voice, evaluated when the note length is known
    always_comb
    begin
        do_tone = 1'b0;
        ended   = 1'b0;
        pos_n   = cur_pos;
        ms_n    = cur_ms + 18'd1;
        if (cur_ms == '0 && audible && freq != '0)
            do_tone = 1'b1;
        else if (audible && q >= GAP && cur_ms == q - GAP)
            do_tone = 1'b0;
        else if (cur_ms >= q)
        begin
            ms_n = '0;
            if ({1'b0, cur_pos} + 9'd1 >= cnt_eff)
            begin
                pos_n = '0;
                ended = 1'b1;
            end
            else
                pos_n = cur_pos + 8'd1;
        end
    end

    always_comb
    begin
        loop_on_next   = loop_on_reg;
        loop_slot_next = loop_slot_reg;
        loop_pos_next  = loop_pos_reg;
        loop_ms_next   = loop_ms_reg;
        eff_on_next    = eff_on_reg;
        eff_slot_next  = eff_slot_reg;
        eff_pos_next   = eff_pos_reg;
        eff_ms_next    = eff_ms_reg;
        run_next       = run_reg;
        period_next    = period_reg;
        ov_next        = ov_reg;
        div_go_next    = (state_reg == tvms_pkg::ST_ENOTE)
                      || (state_reg == tvms_pkg::ST_LNOTE);
        note_nxt       = note_reg;
        slot_nxt       = slot_reg;
        rd_slot_en     = 1'b0;
        rd_slot_addr   = cur_slot;
        rd_note_en     = 1'b0;
        rd_note_addr   = AW'({1'b0, slot_rd[25:18]} + {1'b0, cur_pos});
        dreq.start     = 1'b0;
        dreq.dividend  = 20'd15000 * 20'(note_rd[4:0]);
        dreq.divisor   = {3'd0, slot_reg[8:0]};
        if (out_valid && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            tvms_pkg::ST_ERD, tvms_pkg::ST_LRD:
                rd_slot_en = 1'b1;
            tvms_pkg::ST_ENOTE, tvms_pkg::ST_LNOTE:
            begin
                slot_nxt   = slot_rd;
                rd_note_en = 1'b1;
                dreq.start = 1'b0;
            end
            tvms_pkg::ST_EDIV, tvms_pkg::ST_LDIV:
            begin
                // note data arrives in the cycle after the note read
                note_nxt   = note_rd;
                dreq.start = div_go_reg;
                if (drsp.done)
                begin
                    if (do_tone)
                    begin
                        dreq.start    = 1'b1;
                        dreq.dividend = 20'd1000000;
                        dreq.divisor  = freq;
                    end
                    else
                    begin
                        if (audible && q >= GAP && cur_ms == q - GAP)
                            run_next = 1'b0;
                        if (is_eff)
                        begin
                            eff_pos_next = pos_n;
                            eff_ms_next  = ms_n;
                            if (ended)
                            begin
                                eff_on_next  = 1'b0;
                                eff_pos_next = '0;
                                eff_ms_next  = '0;
                            end
                        end
                        else
                        begin
                            loop_pos_next = pos_n;
                            loop_ms_next  = ms_n;
                        end
                    end
                end
            end
            tvms_pkg::ST_EPER, tvms_pkg::ST_LPER:
                if (drsp.done)
                begin
                    run_next    = 1'b1;
                    period_next = (drsp.quot > 20'd65535) ? 16'hFFFF : drsp.quot[15:0];
                    if (is_eff)
                        eff_ms_next = eff_ms_reg + 18'd1;
                    else
                        loop_ms_next = loop_ms_reg + 18'd1;
                end
            tvms_pkg::ST_OUT:
            begin
                ov_next = 1'b1;
                case (req_reg)
                    tvms_pkg::REQ_LOOP:
                        if (slot_ok && !(loop_on_reg && loop_slot_reg == SW'(song_reg)))
                        begin
                            loop_on_next   = 1'b1;
                            loop_slot_next = SW'(song_reg);
                            loop_pos_next  = '0;
                            loop_ms_next   = '0;
                        end
                    tvms_pkg::REQ_EFFECT:
                        if (slot_ok)
                        begin
                            eff_on_next   = 1'b1;
                            eff_slot_next = SW'(song_reg);
                            eff_pos_next  = '0;
                            eff_ms_next   = '0;
                            run_next      = 1'b0;
                        end
                    tvms_pkg::REQ_STOP:
                    begin
                        loop_on_next  = 1'b0;
                        loop_pos_next = '0;
                        loop_ms_next  = '0;
                        run_next      = 1'b0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tvms_pkg::ST_IDLE;
            loop_on_reg   <= 1'b0;
            loop_slot_reg <= '0;
            loop_pos_reg  <= '0;
            loop_ms_reg   <= '0;
            eff_on_reg    <= 1'b0;
            eff_slot_reg  <= '0;
            eff_pos_reg   <= '0;
            eff_ms_reg    <= '0;
            run_reg       <= 1'b0;
            period_reg    <= '0;
            ov_reg        <= 1'b0;
            div_go_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loop_on_reg   <= loop_on_next;
            loop_slot_reg <= loop_slot_next;
            loop_pos_reg  <= loop_pos_next;
            loop_ms_reg   <= loop_ms_next;
            eff_on_reg    <= eff_on_next;
            eff_slot_reg  <= eff_slot_next;
            eff_pos_reg   <= eff_pos_next;
            eff_ms_reg    <= eff_ms_next;
            run_reg       <= run_next;
            period_reg    <= period_next;
            ov_reg        <= ov_next;
            div_go_reg    <= div_go_next;
        end
    end

    assign out_valid      = ov_reg;
    assign tone_enable    = run_reg;
    assign tone_period_us = period_reg;
    assign tone_compare   = period_reg[15:1];
    assign loop_active    = loop_on_reg;
    assign effect_active  = eff_on_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while a result waits");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tone_period_us))
        else $error("result changed while stalled");
    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == tvms_pkg::ST_OUT |=> out_valid)
        else $error("no result after request");

endmodule
